/* hdl/assert_macros.svh */
// Assertion helpers shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

/* hdl/cpdr_pkg.sv */
package cpdr_pkg;
    localparam int unsigned POOL_DEPTH_DEF   = 64;
    localparam int unsigned BINNED_WIDTH_DEF = 16;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned PREC_W = 32;
    localparam int unsigned RAND_W = 32;
    localparam int unsigned CAP_W  = 7;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_INS_RD,
        ST_INS_CMP,
        ST_EXT_RD,
        ST_EXT_WALK,
        ST_EXT_LAST,
        ST_EXT_MOVE,
        ST_DONE
    } t_state;
endpackage

/* hdl/cpdr_mod.sv */
// Restoring remainder unit: one quotient bit per cycle.
module cpdr_mod
    import cpdr_pkg::*;
#(
    parameter int unsigned DW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [31:0]   i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_rem
);
    localparam int unsigned CW = $clog2(33);

    logic [DW:0]   r_rem;
    logic [31:0]   r_num;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   w_sh;

    assign w_sh  = {r_rem[DW-1:0], r_num[31]};
    assign o_rem = r_rem[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(32);
                r_rem  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_num <= {r_num[30:0], 1'b0};
                if (w_sh >= {1'b0, r_den}) r_rem <= w_sh - {1'b0, r_den};
                else                       r_rem <= w_sh;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* hdl/candidate_pool_duel_roulette.sv */
// Candidate pool with duel replacement and score-weighted extraction.
// Configure capacity over the APB port (register 0, byte address 0) while idle;
// reads return it. Issue an item by raising start with the fields while
// busy is low; i_opcode selects insert (0) or extract (1).
// Each item yields exactly one result, shown for one cycle with o_done high;
// the receiver cannot stall, so no result buffering exists.
// Steps after acceptance: an insert with room, or an extract on an empty pool
// or with a zero score total, goes straight to o_done. An insert on a full
// pool takes the remainder by count in the divider, then a memory read and a
// compare-write. An extract takes the remainder by score total, a read of the
// last entry, a walk down the binned scores reading one entry per cycle, a
// hold of the last entry and a move into the hole.
// busy stays high through the o_done cycle, so the next item is taken in the
// cycle after it; one item is in flight at a time.
// All pool entries live in one synchronous memory (id, binned, precise per
// word) with a registered read port. Reset clears the count, the score
// total and the control state; memory contents are not cleared since every
// entry below the count is written before it is read.
module candidate_pool_duel_roulette
    import cpdr_pkg::*;
#(
    parameter int unsigned POOL_DEPTH   = POOL_DEPTH_DEF,
    parameter int unsigned BINNED_WIDTH = BINNED_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    output logic        o_done,
    input  logic        i_opcode,
    input  logic [31:0] i_cand_id,
    input  logic [15:0] i_cand_binned,
    input  logic [31:0] i_cand_precise,
    input  logic [31:0] i_random_word,
    output logic        o_accepted,
    output logic        o_got_entry,
    output logic [31:0] o_out_id,
    output logic        o_evicted,
    output logic [6:0]  o_pool_count
);
    localparam int unsigned AW  = $clog2(POOL_DEPTH);
    localparam int unsigned NW  = $clog2(POOL_DEPTH + 1);
    localparam int unsigned SW  = BINNED_WIDTH + NW;
    localparam int unsigned DW  = (SW > 32) ? SW : 32;
    localparam int unsigned MW  = ID_W + BINNED_WIDTH + PREC_W;

    // Memory word: {id, binned, precise}
    logic [MW-1:0] r_mem [POOL_DEPTH];
    logic [MW-1:0] r_rdata;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          rd_en, wr_en;
    logic [MW-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    logic [ID_W-1:0]         rd_id;
    logic [BINNED_WIDTH-1:0] rd_bin;
    logic [PREC_W-1:0]       rd_prec;
    assign {rd_id, rd_bin, rd_prec} = r_rdata;

    // Config register
    logic [CAP_W-1:0] r_cap;
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {25'd0, r_cap} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= CAP_W'(64);
        else if (psel && penable && pwrite && pready && paddr == 1'b0)
            r_cap <= pwdata[CAP_W-1:0];
    end

    logic [NW:0] lim;
    always_comb begin
        if (r_cap == '0) lim = (NW+1)'(1);
        else if (32'(r_cap) > POOL_DEPTH) lim = (NW+1)'(POOL_DEPTH);
        else lim = (NW+1)'(r_cap);
    end

    t_state r_st, n_st;
    logic [NW-1:0]           r_cnt;
    logic [SW-1:0]           r_tot;
    logic                    r_op;
    logic [ID_W-1:0]         r_id;
    logic [BINNED_WIDTH-1:0] r_bin;
    logic [PREC_W-1:0]       r_prec;
    logic [31:0]             r_rw;
    logic [AW-1:0]           r_idx;
    logic [SW-1:0]           r_cum;
    logic [SW-1:0]           r_n;
    logic                    r_acc, r_got, r_ev;
    logic [ID_W-1:0]         r_oid;
    logic                    r_kick;

    logic          div_go, div_done;
    logic [DW-1:0] div_den, div_rem;

    cpdr_mod #(.DW(DW)) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (div_go),
        .i_num  (r_rw),
        .i_den  (div_den),
        .o_done (div_done),
        .o_rem  (div_rem)
    );

    assign div_den = (r_op == OP_INSERT) ? DW'(r_cnt) : DW'(r_tot);
    wire ins_room = ((NW+1)'(r_cnt) < lim) && (32'(r_cnt) < POOL_DEPTH);
    wire [SW-1:0] cum_nx = r_cum + SW'(rd_bin);

    // Launch the remainder only when the item waits for it
    wire need_div = (r_op == OP_INSERT) ? (!ins_room && r_cnt != '0)
                                        : (r_cnt != '0 && r_tot != '0);

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (start) n_st = ST_DIV;
            ST_DIV: begin
                if (r_op == OP_INSERT) begin
                    if (ins_room || r_cnt == '0) n_st = ST_DONE;
                    else if (div_done) n_st = ST_INS_RD;
                end else begin
                    if (r_cnt == '0 || r_tot == '0) n_st = ST_DONE;
                    else if (div_done) n_st = ST_EXT_RD;
                end
            end
            ST_INS_RD:   n_st = ST_INS_CMP;
            ST_INS_CMP:  n_st = ST_DONE;
            ST_EXT_RD:   n_st = ST_EXT_WALK;
            ST_EXT_WALK: if (cum_nx > r_n || r_idx == '0) n_st = ST_EXT_LAST;
            ST_EXT_LAST: n_st = ST_EXT_MOVE;
            ST_EXT_MOVE: n_st = ST_DONE;
            ST_DONE:     n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // Memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = {r_id, r_bin, r_prec};
        div_go  = 1'b0;
        unique case (r_st)
            ST_DIV: begin
                if (r_op == OP_INSERT && ins_room) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_cnt);
                end
                div_go = r_kick && need_div;
            end
            ST_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = div_rem[AW-1:0];
            end
            ST_INS_CMP: begin
                wr_en = (r_prec > rd_prec);
            end
            ST_EXT_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_cnt - 1'b1);
            end
            ST_EXT_WALK: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_cnt - 1'b1);
                if (!(cum_nx > r_n || r_idx == '0)) rd_addr = r_idx - 1'b1;
            end
            ST_EXT_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_cnt <= '0;
            r_tot <= '0;
            r_acc <= 1'b0;
            r_got <= 1'b0;
            r_ev  <= 1'b0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                ST_IDLE: if (start) begin
                    r_op   <= i_opcode;
                    r_id   <= i_cand_id;
                    r_bin  <= BINNED_WIDTH'(i_cand_binned);
                    r_prec <= i_cand_precise;
                    r_rw   <= i_random_word;
                    r_acc  <= 1'b0;
                    r_got  <= 1'b0;
                    r_ev   <= 1'b0;
                    r_oid  <= '0;
                end
                ST_DIV: begin
                    if (r_op == OP_INSERT && ins_room) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_tot <= r_tot + SW'(r_bin);
                        r_acc <= 1'b1;
                    end
                    if (div_done) begin
                        if (r_op == OP_INSERT) begin
                            r_idx <= div_rem[AW-1:0];
                        end else begin
                            r_idx <= AW'(r_cnt - 1'b1);
                            r_n   <= div_rem[SW-1:0];
                            r_cum <= '0;
                        end
                    end
                end
                ST_INS_CMP: if (r_prec > rd_prec) begin
                    r_oid <= rd_id;
                    r_tot <= r_tot - SW'(rd_bin) + SW'(r_bin);
                    r_acc <= 1'b1;
                    r_ev  <= 1'b1;
                end
                ST_EXT_WALK: begin
                    r_cum <= cum_nx;
                    if (cum_nx > r_n || r_idx == '0) begin
                        r_oid <= rd_id;
                        r_tot <= r_tot - SW'(rd_bin);
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                ST_EXT_MOVE: begin
                    r_cnt <= r_cnt - 1'b1;
                    r_got <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Mark the first cycle after acceptance, where the divider is launched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kick <= 1'b0;
        else r_kick <= (r_st == ST_IDLE) && start;
    end

    assign busy         = (r_st != ST_IDLE);
    assign o_done       = (r_st == ST_DONE);
    assign o_accepted   = r_acc;
    assign o_got_entry  = r_got;
    assign o_out_id     = r_oid;
    assign o_evicted    = r_ev;
    assign o_pool_count = 7'(r_cnt);
endmodule

/* hdl/cpdr_checker.sv */
`include "assert_macros.svh"
module cpdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_accepted,
    input logic       o_got_entry,
    input logic       o_evicted,
    input logic [6:0] o_pool_count
);
    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `CHK_IMPLY(a_ev_acc, i_clk, i_rst_n, o_done && o_evicted, o_accepted)
    `CHK_IMPLY(a_excl, i_clk, i_rst_n, o_done && o_got_entry, !o_accepted)
    `CHK_IMPLY(a_cnt, i_clk, i_rst_n, 1'b1, o_pool_count <= 7'd64)
endmodule

bind candidate_pool_duel_roulette cpdr_checker u_chk (.*);
